FILE: rtl/acg_pkg.sv
// acg_pkg: shared types, codes, register defaults and sine table math for the
// audio cue tone generator. No dependencies; every rtl file imports it.
package acg_pkg;

    localparam int UNIT_W     = 14;
    localparam int BASE_W     = 27;
    localparam int STEP_W     = 32;
    localparam int RATIO_W    = 32;
    localparam int FADE_W     = 12;
    localparam int GAIN_W     = 24;
    localparam int INDEX_W    = 17;
    localparam int WAVE_W     = 25;
    localparam int PROD_W     = 48;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int SINE_ENTRIES_DEFAULT = 1024;
    localparam int PHASE_BITS_DEFAULT   = 32;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [1:0] CUE_SUCCESS = 2'd0;
    localparam logic [1:0] CUE_ALARM   = 2'd1;
    localparam logic [1:0] CUE_INFO    = 2'd2;
    localparam logic [1:0] CUE_NONE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SAMPLES    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PHASE_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_RATIO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS_DECAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INFO_DECAY      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP       = 3'd5;

    localparam logic [UNIT_W-1:0]  UNIT_SAMPLES_RST    = 14'd2400;
    localparam logic [BASE_W-1:0]  BASE_PHASE_STEP_RST = 27'd19685267;
    localparam logic [RATIO_W-1:0] SWEEP_RATIO_RST     = 32'd2147793775;
    localparam logic [RATIO_W-1:0] SUCCESS_DECAY_RST   = 32'd4293937233;
    localparam logic [RATIO_W-1:0] INFO_DECAY_RST      = 32'd4293593981;
    localparam logic [FADE_W-1:0]  FADE_STEP_RST       = 12'd350;

    localparam logic [GAIN_W-1:0]   GAIN_START = 24'd1677722;
    localparam logic [WAVE_W-1:0]   ONE_Q24    = 25'h100_0000;
    localparam logic [SAMPLE_W-1:0] PCM_MAX    = 16'd32767;

    localparam logic [31:0] SIN_PA1 = 32'd1686629713;
    localparam logic [31:0] SIN_PA3 = 32'd693598668;
    localparam logic [31:0] SIN_PA5 = 32'd85569306;
    localparam logic [31:0] SIN_PA7 = 32'd5026995;
    localparam logic [31:0] SIN_PA9 = 32'd172272;

    typedef struct packed {
        logic [UNIT_W-1:0]  unit_samples;
        logic [BASE_W-1:0]  base_phase_step;
        logic [RATIO_W-1:0] sweep_ratio;
        logic [RATIO_W-1:0] success_decay;
        logic [RATIO_W-1:0] info_decay;
        logic [FADE_W-1:0]  fade_step;
    } acg_cfg_t;

    typedef struct packed {
        logic [31:0]       phase;
        logic [GAIN_W-1:0] gain;
        logic [1:0]        cue;
        logic              last;
    } acg_snap_t;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic              neg;
        logic              last;
    } acg_prod_t;

    // sin(pi/2 * u / 2^30) in unsigned Q1.24 by odd polynomial, Q30 Horner
    function automatic logic [WAVE_W-1:0] quarter_sine(input logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] p;
        logic [63:0] s;
        u2 = (u * u) >> 30;
        p  = 64'(SIN_PA9);
        p  = 64'(SIN_PA7) - ((u2 * p) >> 30);
        p  = 64'(SIN_PA5) - ((u2 * p) >> 30);
        p  = 64'(SIN_PA3) - ((u2 * p) >> 30);
        p  = 64'(SIN_PA1) - ((u2 * p) >> 30);
        s  = (u * p) >> 30;
        s  = (s + 64'd32) >> 6;
        if (s > 64'(ONE_Q24)) begin
            s = 64'(ONE_Q24);
        end
        return WAVE_W'(s);
    endfunction

endpackage

FILE: rtl/acg_cue_ctrl.sv
// acg_cue_ctrl: cue sequencer state (phase, sample index, step, gain, length).
// Updates once per accepted item; hands a snapshot of each sample to the wave path.
// Depends on acg_pkg.
module acg_cue_ctrl import acg_pkg::*; #(
    parameter int PHASE_BITS = PHASE_BITS_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  acg_cfg_t  cfg,
    input  logic      s_valid,
    input  logic      s_ready,
    input  logic      s_command,
    input  logic [1:0] s_cue,
    output logic      snap_valid,
    output acg_snap_t snap
);

    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [INDEX_W-1:0]    index_reg, index_next;
    logic [INDEX_W-1:0]    len_reg, len_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [GAIN_W-1:0]     gain_reg, gain_next;
    logic [1:0]            cue_reg, cue_next;
    logic                  playing_reg, playing_next;

    logic                  accept;
    logic                  start_ok;
    logic                  tick;
    logic [INDEX_W:0]      next_idx;
    logic                  last;
    logic [INDEX_W:0]      two_u, four_u, six_u;
    logic [63:0]           sweep_prod;
    logic [32:0]           sweep_q;
    logic [STEP_W-1:0]     step_sweep;
    logic [RATIO_W-1:0]    decay;
    logic [56:0]           decay_prod;
    logic [GAIN_W-1:0]     gain_decay;
    logic [GAIN_W-1:0]     gain_fade;
    logic [STEP_W-1:0]     base_1, base_2, base_3, base_4, base_8;

    assign accept   = s_valid && s_ready;
    assign start_ok = accept && (s_command == CMD_START) && (s_cue != CUE_NONE)
                      && (cfg.unit_samples != '0);
    assign tick     = accept && (s_command == CMD_TICK) && playing_reg;

    assign next_idx = (INDEX_W+1)'(index_reg) + (INDEX_W+1)'(1);
    assign last     = next_idx >= (INDEX_W+1)'(len_reg);

    assign two_u  = (INDEX_W+1)'(cfg.unit_samples) << 1;
    assign four_u = (INDEX_W+1)'(cfg.unit_samples) << 2;
    assign six_u  = four_u + two_u;

    assign base_1 = STEP_W'(cfg.base_phase_step);
    assign base_2 = base_1 << 1;
    assign base_3 = base_2 + base_1;
    assign base_4 = base_1 << 2;
    assign base_8 = base_1 << 3;

    assign sweep_prod = 64'(step_reg) * 64'(cfg.sweep_ratio) + 64'h4000_0000;
    assign sweep_q    = sweep_prod[63:31];
    assign step_sweep = sweep_q[32] ? '1 : sweep_q[31:0];

    assign decay      = (cue_reg == CUE_SUCCESS) ? cfg.success_decay : cfg.info_decay;
    assign decay_prod = 57'(gain_reg) * 57'(decay) + 57'h8000_0000;
    assign gain_decay = decay_prod[55:32];
    assign gain_fade  = (gain_reg > GAIN_W'(cfg.fade_step))
                        ? gain_reg - GAIN_W'(cfg.fade_step) : '0;

    always_comb begin
        phase_next   = phase_reg;
        index_next   = index_reg;
        len_next     = len_reg;
        step_next    = step_reg;
        gain_next    = gain_reg;
        cue_next     = cue_reg;
        playing_next = playing_reg;
        if (start_ok) begin
            phase_next   = '0;
            index_next   = '0;
            gain_next    = GAIN_START;
            cue_next     = s_cue;
            playing_next = 1'b1;
            case (s_cue)
                CUE_SUCCESS: begin
                    len_next  = INDEX_W'(four_u);
                    step_next = base_4;
                end
                CUE_ALARM: begin
                    len_next  = INDEX_W'((INDEX_W+1)'(cfg.unit_samples) << 3);
                    step_next = base_2;
                end
                default: begin
                    len_next  = INDEX_W'(two_u + (INDEX_W+1)'(cfg.unit_samples));
                    step_next = base_3;
                end
            endcase
        end else if (tick) begin
            phase_next = phase_reg + step_reg[STEP_W-1 -: PHASE_BITS];
            index_next = INDEX_W'(next_idx);
            if (last) begin
                playing_next = 1'b0;
            end
            case (cue_reg)
                CUE_SUCCESS: begin
                    step_next = (next_idx < two_u) ? step_sweep : base_8;
                    gain_next = gain_decay;
                end
                CUE_ALARM: begin
                    step_next = ((next_idx < two_u) || (next_idx >= four_u)) ? base_2 : base_1;
                    gain_next = (next_idx <= six_u) ? GAIN_START : gain_fade;
                end
                default: begin
                    step_next = base_3;
                    gain_next = gain_decay;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            index_reg   <= '0;
            len_reg     <= '0;
            step_reg    <= '0;
            gain_reg    <= '0;
            cue_reg     <= CUE_SUCCESS;
            playing_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            index_reg   <= index_next;
            len_reg     <= len_next;
            step_reg    <= step_next;
            gain_reg    <= gain_next;
            cue_reg     <= cue_next;
            playing_reg <= playing_next;
        end
    end

    assign snap_valid = tick;
    assign snap.phase = 32'(phase_reg) << (32 - PHASE_BITS);
    assign snap.gain  = gain_reg;
    assign snap.cue   = cue_reg;
    assign snap.last  = last;

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        playing_reg |-> (index_reg < len_reg))
        else $error("sample index beyond cue length while playing");

    a_last_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_valid && snap.last) |=> !playing_reg)
        else $error("cue still playing after its final sample");

    a_bad_cue_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_command == CMD_START) && (s_cue == CUE_NONE))
        |=> (playing_reg == $past(playing_reg)) && (cue_reg == $past(cue_reg)))
        else $error("start with unused cue code changed state");

    a_cue_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        playing_reg |-> (cue_reg != CUE_NONE))
        else $error("playing with unused cue code");

endmodule

FILE: rtl/acg_wave.sv
// acg_wave: waveform stage (quarter-wave sine ROM, square, triangle) and gain
// multiply, two registered stages with per-stage flow control. Depends on acg_pkg.
module acg_wave import acg_pkg::*; #(
    parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      snap_valid,
    input  acg_snap_t snap,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output acg_prod_t out_item
);

    localparam int AW = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int PW = 30 + AW;

    typedef logic [WAVE_W-1:0] rom_t [0:SINE_TABLE_ENTRIES];

    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] u;
        for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
            u      = (64'(k) << 30) / 64'(SINE_TABLE_ENTRIES);
            rom[k] = quarter_sine(u);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [PW-1:0]     idx_prod;
    logic [AW-1:0]     rom_idx;
    logic [AW-1:0]     rom_addr;
    logic [26:0]       tri_q;
    logic [26:0]       tri_v;
    logic              wave_sine;
    logic              wave_neg;
    logic [WAVE_W-1:0] wave_mag;

    logic              s1_valid_reg;
    logic [WAVE_W-1:0] s1_rom_reg;
    logic [WAVE_W-1:0] s1_alt_reg;
    logic              s1_sine_reg;
    logic              s1_neg_reg;
    logic [GAIN_W-1:0] s1_gain_reg;
    logic              s1_last_reg;
    logic              s1_rdy;
    logic              s2_rdy;
    logic [WAVE_W-1:0] s1_mag;

    logic              s2_valid_reg;
    acg_prod_t         s2_item_reg;

    assign idx_prod = PW'(snap.phase[29:0]) * PW'(SINE_TABLE_ENTRIES);
    assign rom_idx  = idx_prod[PW-1:30];
    assign rom_addr = snap.phase[30] ? AW'(SINE_TABLE_ENTRIES) - rom_idx : rom_idx;

    assign tri_q = 27'(snap.phase[31:6]);

    always_comb begin
        case (snap.phase[31:30])
            2'b00:        tri_v = tri_q;
            2'b01, 2'b10: tri_v = 27'h200_0000 - tri_q;
            default:      tri_v = tri_q - 27'h400_0000;
        endcase
    end

    always_comb begin
        case (snap.cue)
            CUE_SUCCESS: begin
                wave_sine = 1'b1;
                wave_neg  = snap.phase[31];
                wave_mag  = '0;
            end
            CUE_ALARM: begin
                wave_sine = 1'b0;
                wave_neg  = snap.phase[31];
                wave_mag  = ONE_Q24;
            end
            default: begin
                wave_sine = 1'b0;
                wave_neg  = tri_v[26];
                wave_mag  = WAVE_W'(tri_v[26] ? 27'd0 - tri_v : tri_v);
            end
        endcase
    end

    assign s2_rdy   = !s2_valid_reg || out_ready;
    assign s1_rdy   = !s1_valid_reg || s2_rdy;
    assign in_ready = s1_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_rdy) begin
                s1_valid_reg <= snap_valid;
            end
            if (s2_rdy) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid) begin
            s1_rom_reg  <= SINE_ROM[rom_addr];
            s1_alt_reg  <= wave_mag;
            s1_sine_reg <= wave_sine;
            s1_neg_reg  <= wave_neg;
            s1_gain_reg <= snap.gain;
            s1_last_reg <= snap.last;
        end
    end

    assign s1_mag = s1_sine_reg ? s1_rom_reg : s1_alt_reg;

    always_ff @(posedge aclk) begin
        if (s2_rdy && s1_valid_reg) begin
            s2_item_reg.prod <= PROD_W'(s1_mag) * PROD_W'(s1_gain_reg);
            s2_item_reg.neg  <= s1_neg_reg;
            s2_item_reg.last <= s1_last_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

FILE: rtl/acg_pcm_out.sv
// acg_pcm_out: scales the gained wave to 16-bit PCM with rounding and clamping,
// and holds the result item in the output register. Depends on acg_pkg.
module acg_pcm_out import acg_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  acg_prod_t           in_item,
    output logic                in_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SAMPLE_W-1:0] m_sample,
    output logic                m_last
);

    logic [63:0]         prod_ext;
    logic [63:0]         scaled;
    logic [SAMPLE_W-1:0] rnd;
    logic [SAMPLE_W-1:0] clamped;
    logic [SAMPLE_W-1:0] pcm;
    logic                out_rdy;

    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_sample_reg;
    logic                m_last_reg;

    assign prod_ext = 64'(in_item.prod);
    assign scaled   = (prod_ext << 15) - prod_ext + 64'h0000_8000_0000_0000;
    assign rnd      = scaled[63:48];
    assign clamped  = (rnd > PCM_MAX) ? PCM_MAX : rnd;
    assign pcm      = in_item.neg ? SAMPLE_W'(0) - clamped : clamped;

    assign out_rdy  = !m_valid_reg || m_ready;
    assign in_ready = out_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_rdy) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy && in_valid) begin
            m_sample_reg <= pcm;
            m_last_reg   <= in_item.last;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;
    assign m_last   = m_last_reg;

endmodule

FILE: rtl/audio_cue_tone_generator.sv
// Audio cue tone generator: a start item (command 0) arms the success, alarm or
// info cue and gives no result; each tick item (command 1) while a cue plays gives
// one signed 16-bit PCM sample, with last set on the cue's final sample. Ticks while
// idle are accepted and dropped. One item is accepted per clock cycle unless m_ready
// holds the output back; the cue state (phase, step, gain) updates once per item,
// through one step multiplier and one gain multiplier. A sample reaches m_sample
// through the registered sine ROM read, gain multiply and PCM scale stage, each of
// which can hold an item while the output waits. The user writes the configuration
// registers through cfg_wr_en/cfg_index/cfg_wdata only while no cue item is in
// flight; the block does not enforce it. Depends on acg_pkg and the acg_* submodules.
module audio_cue_tone_generator import acg_pkg::*; #(
    parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEFAULT,
    parameter int PHASE_BITS         = PHASE_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [1:0]            s_cue,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SAMPLE_W-1:0]   m_sample,
    output logic                  m_last,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    acg_cfg_t  cfg_reg;
    logic      snap_valid;
    acg_snap_t snap;
    logic      wave_valid;
    logic      wave_ready;
    acg_prod_t wave_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.unit_samples    <= UNIT_SAMPLES_RST;
            cfg_reg.base_phase_step <= BASE_PHASE_STEP_RST;
            cfg_reg.sweep_ratio     <= SWEEP_RATIO_RST;
            cfg_reg.success_decay   <= SUCCESS_DECAY_RST;
            cfg_reg.info_decay      <= INFO_DECAY_RST;
            cfg_reg.fade_step       <= FADE_STEP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_UNIT_SAMPLES:    cfg_reg.unit_samples    <= cfg_wdata[UNIT_W-1:0];
                CFG_BASE_PHASE_STEP: cfg_reg.base_phase_step <= cfg_wdata[BASE_W-1:0];
                CFG_SWEEP_RATIO:     cfg_reg.sweep_ratio     <= cfg_wdata[RATIO_W-1:0];
                CFG_SUCCESS_DECAY:   cfg_reg.success_decay   <= cfg_wdata[RATIO_W-1:0];
                CFG_INFO_DECAY:      cfg_reg.info_decay      <= cfg_wdata[RATIO_W-1:0];
                CFG_FADE_STEP:       cfg_reg.fade_step       <= cfg_wdata[FADE_W-1:0];
                default: ;
            endcase
        end
    end

    acg_cue_ctrl #(
        .PHASE_BITS (PHASE_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_cue      (s_cue),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    acg_wave #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_wave (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_valid (snap_valid),
        .snap       (snap),
        .in_ready   (s_ready),
        .out_valid  (wave_valid),
        .out_ready  (wave_ready),
        .out_item   (wave_item)
    );

    acg_pcm_out u_pcm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (wave_valid),
        .in_item  (wave_item),
        .in_ready (wave_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_sample (m_sample),
        .m_last   (m_last)
    );

endmodule
